[sv/bpd_pkg.sv]
// Package: constants, widths and register map of the baseline peak detector.
`timescale 1ns / 1ps

package bpd_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int SAMPLE_BITS   = 16;

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
    localparam int THR_W   = 16;
    localparam int LEVEL_W = 16;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // signed width that holds sample*n, threshold*n and the sum with room to spare
    localparam int PROD_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS + CNT_W : THR_W + CNT_W;
    localparam int EXC_W   = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 2;

    localparam logic [THR_W-1:0] ENTRY_THR_RESET = THR_W'(26);
    localparam logic [THR_W-1:0] EXIT_THR_RESET  = THR_W'(51);

    typedef enum logic [0:0] {
        REG_ENTRY_THR = 1'b0,
        REG_EXIT_THR  = 1'b1
    } reg_idx_t;

endpackage

[sv/baseline_peak_detector.sv]
// Top level: moving-average baseline peak detector with a ring memory of history.
// A sample beat is registered in the accept stage, then in the result register.
// Throughput: one sample per cycle unless stalled; the ring memory takes one read
// (accept stage) and one write (update stage) per cycle, each at its own slot.
// Reset: rst_n clears control, sum, fill count and tracking state, and loads the
// thresholds with 26 and 51; the ring memory itself is not cleared.
`timescale 1ns / 1ps

module baseline_peak_detector
    import bpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   peak_found,
    output logic                   tracking,
    output logic [LEVEL_W-1:0]     peak_level,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ring memory
    logic [SAMPLE_BITS-1:0] ring_mem [HISTORY_DEPTH];
    logic [SAMPLE_BITS-1:0] old_reg;

    // config
    logic [THR_W-1:0] entry_thr_reg;
    logic [THR_W-1:0] exit_thr_reg;

    // accept stage
    logic [SLOT_W-1:0]      slot_reg;
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SLOT_W-1:0]      s1_slot_reg;

    // running state
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   armed_reg;
    logic                   reported_reg;
    logic [SAMPLE_BITS-1:0] max_reg;

    // result register
    logic                   out_valid_reg;
    logic                   peak_reg;
    logic                   track_reg;
    logic [LEVEL_W-1:0]     level_reg;

    logic accept;
    logic advance;

    logic                   full;
    logic [CNT_W-1:0]       count_next;
    logic [SUM_W-1:0]       sum_next;
    logic signed [EXC_W-1:0] excess;
    logic signed [EXC_W-1:0] entry_bound;
    logic signed [EXC_W-1:0] exit_bound;
    logic                   armed_next;
    logic                   reported_next;
    logic [SAMPLE_BITS-1:0] max_next;
    logic                   peak_next;
    logic [SAMPLE_BITS-1:0] max_upd;
    logic [SLOT_W-1:0]      slot_next;

    assign advance      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    // Read slot of the next item always differs from the slot being written,
    // and a slot is read again only after its write has landed: no forwarding.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_reg <= ring_mem[slot_reg];
        end
        if (advance)
        begin
            ring_mem[s1_slot_reg] <= s1_sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_slot_reg   <= slot_reg;
        end
    end

    // update stage arithmetic
    always_comb
    begin
        full       = (count_reg == CNT_W'(HISTORY_DEPTH));
        count_next = full ? count_reg : count_reg + 1'b1;
        sum_next   = sum_reg - (full ? SUM_W'(old_reg) : '0) + SUM_W'(s1_sample_reg);

        // (cur - mean) * n compared against threshold * n
        excess      = $signed(EXC_W'(s1_sample_reg) * EXC_W'(count_next) - EXC_W'(sum_next));
        entry_bound = $signed(EXC_W'(entry_thr_reg) * EXC_W'(count_next));
        exit_bound  = $signed(EXC_W'(exit_thr_reg) * EXC_W'(count_next));

        armed_next    = armed_reg;
        reported_next = reported_reg;
        max_next      = max_reg;
        peak_next     = 1'b0;
        max_upd       = (s1_sample_reg > max_reg) ? s1_sample_reg : max_reg;

        if (!armed_reg)
        begin
            if (excess > entry_bound)
            begin
                armed_next    = 1'b1;
                max_next      = s1_sample_reg;
                reported_next = 1'b0;
            end
        end
        else
        begin
            max_next = max_upd;
            if ((s1_sample_reg < max_upd) && !reported_reg)
            begin
                reported_next = 1'b1;
                armed_next    = 1'b0;
                peak_next     = 1'b1;
            end
            else if (excess < exit_bound)
            begin
                armed_next    = 1'b0;
                reported_next = 1'b0;
                max_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            armed_reg     <= 1'b0;
            reported_reg  <= 1'b0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                slot_reg <= slot_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                count_reg     <= count_next;
                sum_reg       <= sum_next;
                armed_reg     <= armed_next;
                reported_reg  <= reported_next;
                max_reg       <= max_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            peak_reg  <= peak_next;
            track_reg <= armed_next;
            level_reg <= LEVEL_W'(max_next);
        end
    end

    assign result_valid = out_valid_reg;
    assign peak_found   = peak_reg;
    assign tracking     = track_reg;
    assign peak_level   = level_reg;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_thr_reg <= ENTRY_THR_RESET;
            exit_thr_reg  <= EXIT_THR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_ENTRY_THR: entry_thr_reg <= pwdata[THR_W-1:0];
                REG_EXIT_THR:  exit_thr_reg  <= pwdata[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_ENTRY_THR: prdata = DATA_W'(entry_thr_reg);
            REG_EXIT_THR:  prdata = DATA_W'(exit_thr_reg);
            default:       prdata = '0;
        endcase
    end

endmodule

[sv/bpd_checker.sv]
// Checker: port-level assertions for the baseline peak detector, bound to the top level.
`timescale 1ns / 1ps

module bpd_checker
    import bpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_stall,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   peak_found,
    input  logic                   tracking,
    input  logic [LEVEL_W-1:0]     peak_level
);

    // a reported peak always ends tracking
    a_peak_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && peak_found |-> !tracking)
        else $error("peak reported while still tracking");

    // a peak lies strictly above some later sample, so its level is nonzero
    a_peak_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && peak_found |-> peak_level != '0)
        else $error("peak reported with zero level");

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(peak_found) && $stable(tracking) && $stable(peak_level))
        else $error("stalled result beat changed");

    // with the result register empty the input is never stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("input stalled with output empty");

endmodule

bind baseline_peak_detector bpd_checker u_bpd_checker (.*);
